// File: sv/goldilocks_field_alu_unit_assert.svh
// Assertion macros shared by the Goldilocks field unit.
`ifndef GOLDILOCKS_FIELD_ALU_UNIT_ASSERT_SVH
`define GOLDILOCKS_FIELD_ALU_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define GFA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define GFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/gfa_pkg.sv
// Shared types and constants for the Goldilocks field unit.
`timescale 1ns / 1ps

package gfa_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = 32;

	localparam logic [WORD_W-1:0] EPSILON = 64'h0000_0000_FFFF_FFFF;
	localparam logic [WORD_W-1:0] PRIME   = 64'hFFFF_FFFF_0000_0001;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [HALF_W-1:0] half_t;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_NEG   = 3'd2,
		OP_MUL   = 3'd3,
		OP_CANON = 3'd4
	} op_t;

	// Load enables of the three internal pipeline registers.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} adv_t;

endpackage

// File: sv/gfa_mul_pipe.sv
// Three-stage Goldilocks modular multiplier with a final combinational fold.
`timescale 1ns / 1ps

module gfa_mul_pipe (
	input  logic          clk,
	input  gfa_pkg::adv_t adv,
	input  gfa_pkg::word_t a,
	input  gfa_pkg::word_t b,
	output gfa_pkg::word_t product
);

	gfa_pkg::word_t p00_s1, p01_s1, p10_s1, p11_s1;
	gfa_pkg::word_t lo_s2, hi_s2;
	gfa_pkg::word_t t0_s3, t1_s3;

	logic [gfa_pkg::HALF_W+1:0] mid;
	gfa_pkg::word_t             hi;
	logic [gfa_pkg::WORD_W:0]   t0_raw;
	gfa_pkg::word_t             t0_fix;
	gfa_pkg::word_t             hi_lo_ext;
	logic [gfa_pkg::WORD_W:0]   r_raw;
	gfa_pkg::word_t             r_fix;

	// Stage 1: four 32 x 32 partial products.
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			p00_s1 <= gfa_pkg::WORD_W'(a[31:0])  * gfa_pkg::WORD_W'(b[31:0]);
			p01_s1 <= gfa_pkg::WORD_W'(a[31:0])  * gfa_pkg::WORD_W'(b[63:32]);
			p10_s1 <= gfa_pkg::WORD_W'(a[63:32]) * gfa_pkg::WORD_W'(b[31:0]);
			p11_s1 <= gfa_pkg::WORD_W'(a[63:32]) * gfa_pkg::WORD_W'(b[63:32]);
		end
	end

	// Stage 2: assemble the 128-bit product as two words.
	always_comb begin
		mid = {2'b00, p00_s1[63:32]} + {2'b00, p01_s1[31:0]} + {2'b00, p10_s1[31:0]};
		hi  = p11_s1 + {32'd0, p01_s1[63:32]} + {32'd0, p10_s1[63:32]}
			+ {62'd0, mid[33:32]};
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			lo_s2 <= {mid[31:0], p00_s1[31:0]};
			hi_s2 <= hi;
		end
	end

	// Stage 3: lo - hi_hi with borrow fold; hi_lo * EPSILON is a shift and subtract.
	always_comb begin
		t0_raw    = {1'b0, lo_s2} - {33'd0, hi_s2[63:32]};
		t0_fix    = t0_raw[63:0] - gfa_pkg::EPSILON;
		hi_lo_ext = {32'd0, hi_s2[31:0]};
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			t0_s3 <= t0_raw[64] ? t0_fix : t0_raw[63:0];
			t1_s3 <= {hi_s2[31:0], 32'd0} - hi_lo_ext;
		end
	end

	// A carry out of the final add is worth EPSILON.
	always_comb begin
		r_raw   = {1'b0, t0_s3} + {1'b0, t1_s3};
		r_fix   = r_raw[63:0] + gfa_pkg::EPSILON;
		product = r_raw[64] ? r_fix : r_raw[63:0];
	end

endmodule

// File: sv/gfa_misc_pipe.sv
// Three-stage pipeline for add, subtract, negate and canonicalise.
`timescale 1ns / 1ps

module gfa_misc_pipe (
	input  logic           clk,
	input  gfa_pkg::adv_t  adv,
	input  gfa_pkg::word_t a,
	input  gfa_pkg::word_t b,
	input  gfa_pkg::op_t   op_s2,
	output gfa_pkg::word_t result_s3
);

	logic [gfa_pkg::WORD_W:0] sum_s1, diff_s1;
	gfa_pkg::word_t           canon_s1;
	logic                     zero_s1;

	gfa_pkg::word_t add_s2, sub_s2, neg_s2, canon_s2;
	logic           add_c_s2, sub_b_s2;

	logic [gfa_pkg::WORD_W:0] canon_raw;
	logic [gfa_pkg::WORD_W:0] add_fold;
	logic [gfa_pkg::WORD_W:0] sub_fold;

	// Stage 1: raw sum and difference, and the canonical form of a.
	assign canon_raw = {1'b0, a} - {1'b0, gfa_pkg::PRIME};

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			sum_s1   <= {1'b0, a} + {1'b0, b};
			diff_s1  <= {1'b0, a} - {1'b0, b};
			canon_s1 <= canon_raw[64] ? a : canon_raw[63:0];
			zero_s1  <= (a == '0);
		end
	end

	// Stage 2: first carry or borrow fold, and the negation.
	always_comb begin
		add_fold = {1'b0, sum_s1[63:0]} + {1'b0, gfa_pkg::EPSILON};
		sub_fold = {1'b0, diff_s1[63:0]} - {1'b0, gfa_pkg::EPSILON};
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			add_s2   <= sum_s1[64] ? add_fold[63:0] : sum_s1[63:0];
			add_c_s2 <= sum_s1[64] & add_fold[64];
			sub_s2   <= diff_s1[64] ? sub_fold[63:0] : diff_s1[63:0];
			sub_b_s2 <= diff_s1[64] & sub_fold[64];
			neg_s2   <= zero_s1 ? '0 : gfa_pkg::PRIME - canon_s1;
			canon_s2 <= canon_s1;
		end
	end

	// Stage 3: second fold and selection by operation.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			unique case (op_s2)
				gfa_pkg::OP_ADD: begin
					result_s3 <= add_c_s2 ? add_s2 + gfa_pkg::EPSILON : add_s2;
				end
				gfa_pkg::OP_SUB: begin
					result_s3 <= sub_b_s2 ? sub_s2 - gfa_pkg::EPSILON : sub_s2;
				end
				gfa_pkg::OP_NEG:   result_s3 <= neg_s2;
				gfa_pkg::OP_CANON: result_s3 <= canon_s2;
				default:           result_s3 <= '0;
			endcase
		end
	end

endmodule

// File: sv/goldilocks_field_alu_unit.sv
// Throughput: one item per cycle while out_stall does not hold the output; the multiplier is split
// into three register stages plus an output register, and the other operations run alongside in step.
// Each stage loads only when empty or when the stage after it moves, so bubbles close up.
// Reset clears the valid bits of every stage; data registers are not reset.
`timescale 1ns / 1ps

module goldilocks_field_alu_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [63:0] first_operand,
	input  logic [63:0] second_operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value
);

	`include "goldilocks_field_alu_unit_assert.svh"

	logic v_s1, v_s2, v_s3;
	logic en_s4;
	gfa_pkg::adv_t adv;

	gfa_pkg::op_t   op_s1, op_s2, op_s3;
	gfa_pkg::word_t product;
	gfa_pkg::word_t misc_s3;

	always_comb begin
		en_s4  = !out_valid || !out_stall;
		adv.s3 = !v_s3 || en_s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign in_stall = !adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= in_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (en_s4)  out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) op_s1 <= gfa_pkg::op_t'(operation);
		if (adv.s2) op_s2 <= op_s1;
		if (adv.s3) op_s3 <= op_s2;
		if (en_s4)  value <= (op_s3 == gfa_pkg::OP_MUL) ? product : misc_s3;
	end

	gfa_mul_pipe u_mul (
		.clk     (clk),
		.adv     (adv),
		.a       (first_operand),
		.b       (second_operand),
		.product (product)
	);

	gfa_misc_pipe u_misc (
		.clk       (clk),
		.adv       (adv),
		.a         (first_operand),
		.b         (second_operand),
		.op_s2     (op_s2),
		.result_s3 (misc_s3)
	);

	// The input is only held off when every stage holds an item.
	`GFA_ASSERT_NOW(a_stall_full, in_stall, v_s1 && v_s2 && v_s3 && out_valid, "stall with a free stage")
	// A canonical result lies below the prime.
	`GFA_ASSERT_NOW(a_canon_range, v_s3 && (op_s3 == gfa_pkg::OP_CANON), misc_s3 < gfa_pkg::PRIME, "canonical result out of range")
	// An item leaving the last internal stage appears on the output next cycle.
	`GFA_ASSERT_NEXT(a_s3_to_out, v_s3 && en_s4, out_valid, "item lost between stage three and output")

endmodule

// File: sim/goldilocks_field_alu_unit_tb.sv
// Self-checking testbench for the Goldilocks prime field arithmetic unit.
`timescale 1ns / 1ps

module goldilocks_field_alu_unit_tb;
	import gfa_pkg::*;

	// Operation codes that the unit does not define; each must give a zero result.
	localparam logic [2:0] OP_UNDEF_5 = 3'd5;
	localparam logic [2:0] OP_UNDEF_6 = 3'd6;
	localparam logic [2:0] OP_UNDEF_7 = 3'd7;

	localparam word_t ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam word_t PRIME_LESS_1 = 64'hFFFF_FFFF_0000_0000;
	localparam word_t TOP_BIT      = 64'h8000_0000_0000_0000;

	localparam int N_DIRECTED    = 24;
	localparam int N_RANDOM      = 1950;
	localparam int LONG_HOLD     = 100;
	localparam int MAX_REPORTED  = 10;
	localparam int DRAIN_CYCLES  = 12;

	typedef struct {
		logic [2:0] op;
		word_t      a;
		word_t      b;
		bit         fixed;
		word_t      want;
	} field_vector_t;

	typedef struct {
		logic [2:0] op;
		word_t      a;
		word_t      b;
		word_t      value;
	} field_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  operation;
	logic [63:0] first_operand;
	logic [63:0] second_operand;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] value;

	logic hold_request = 1'b0;
	logic steady_run = 1'b0;

	field_item_t awaited_values[$];
	int          mismatches = 0;
	int          burst_left = 0;

	field_vector_t directed_vectors [N_DIRECTED] = '{
		'{OP_ADD, 64'd0, 64'd0, 1'b1, 64'd0},
		'{OP_ADD, ALL_ONES, ALL_ONES, 1'b0, 64'd0},
		'{OP_ADD, PRIME, EPSILON, 1'b0, 64'd0},
		'{OP_ADD, ALL_ONES, 64'd1, 1'b0, 64'd0},
		'{OP_SUB, 64'd0, 64'd0, 1'b1, 64'd0},
		'{OP_SUB, 64'd0, ALL_ONES, 1'b0, 64'd0},
		'{OP_SUB, 64'd0, 64'd1, 1'b0, 64'd0},
		'{OP_SUB, ALL_ONES, 64'd0, 1'b1, ALL_ONES},
		'{OP_SUB, EPSILON, PRIME, 1'b0, 64'd0},
		'{OP_NEG, 64'd0, ALL_ONES, 1'b1, 64'd0},
		'{OP_NEG, PRIME, 64'd0, 1'b1, PRIME},
		'{OP_NEG, 64'd1, ALL_ONES, 1'b1, PRIME_LESS_1},
		'{OP_NEG, ALL_ONES, 64'd0, 1'b0, 64'd0},
		'{OP_MUL, 64'd0, ALL_ONES, 1'b1, 64'd0},
		'{OP_MUL, 64'd1, ALL_ONES, 1'b1, ALL_ONES},
		'{OP_MUL, ALL_ONES, ALL_ONES, 1'b0, 64'd0},
		'{OP_MUL, PRIME, PRIME, 1'b0, 64'd0},
		'{OP_MUL, TOP_BIT, TOP_BIT, 1'b0, 64'd0},
		'{OP_CANON, PRIME, ALL_ONES, 1'b1, 64'd0},
		'{OP_CANON, PRIME_LESS_1, 64'd0, 1'b1, PRIME_LESS_1},
		'{OP_CANON, ALL_ONES, 64'd0, 1'b1, 64'h0000_0000_FFFF_FFFE},
		'{OP_UNDEF_5, ALL_ONES, ALL_ONES, 1'b1, 64'd0},
		'{OP_UNDEF_6, PRIME, 64'd1, 1'b1, 64'd0},
		'{OP_UNDEF_7, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'd0}
	};

	goldilocks_field_alu_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value)
	);

	always #6 clk = ~clk;

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	// Field result as the unit computes it, including its non-canonical outputs.
	function automatic word_t field_result(logic [2:0] op, word_t a, word_t b);
		logic [WORD_W:0]     wide;
		logic [2*WORD_W-1:0] product;
		word_t               lo;
		word_t               diff;
		word_t               fold;
		word_t               canon_a;
		half_t               hi_lo;
		half_t               hi_hi;
		logic                second_borrow;

		canon_a = (a >= PRIME) ? a - PRIME : a;
		case (op)
			OP_ADD: begin
				wide = {1'b0, a} + {1'b0, b};
				if (wide[WORD_W]) begin
					wide = {1'b0, wide[WORD_W-1:0]} + {1'b0, EPSILON};
					if (wide[WORD_W])
						wide[WORD_W-1:0] = wide[WORD_W-1:0] + EPSILON;
				end
				return wide[WORD_W-1:0];
			end
			OP_SUB: begin
				diff = a - b;
				if (a < b) begin
					second_borrow = diff < EPSILON;
					diff = diff - EPSILON;
					if (second_borrow)
						diff = diff - EPSILON;
				end
				return diff;
			end
			OP_NEG: begin
				return (a == '0) ? '0 : PRIME - canon_a;
			end
			OP_MUL: begin
				product = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
				lo    = product[WORD_W-1:0];
				hi_lo = product[WORD_W+HALF_W-1:WORD_W];
				hi_hi = product[2*WORD_W-1:WORD_W+HALF_W];
				diff  = lo - {{HALF_W{1'b0}}, hi_hi};
				if (lo < {{HALF_W{1'b0}}, hi_hi})
					diff = diff - EPSILON;
				fold = {{HALF_W{1'b0}}, hi_lo} * EPSILON;
				wide = {1'b0, diff} + {1'b0, fold};
				return wide[WORD_W] ? wide[WORD_W-1:0] + EPSILON : wide[WORD_W-1:0];
			end
			OP_CANON: begin
				return canon_a;
			end
			default: begin
				return '0;
			end
		endcase
	endfunction

	// Operands lean towards the values where carries, borrows and reductions change.
	function automatic word_t pick_operand();
		word_t w;

		w = {$urandom, $urandom};
		case ($urandom_range(0, 11))
			0: w = '0;
			1: w = ALL_ONES;
			2: w = PRIME;
			3: w = {32'hFFFF_FFFF, w[31:0]};
			4: w = PRIME_LESS_1 - w[7:0];
			5: w = EPSILON;
			6: w = {32'h0, w[31:0]};
			7: w = {w[63:32], 32'h0};
			8: w = word_t'(1) << w[5:0];
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] pick_operation();
		if ($urandom_range(0, 99) < 5)
			return 3'($urandom_range(OP_UNDEF_5, OP_UNDEF_7));
		return 3'($urandom_range(OP_ADD, OP_CANON));
	endfunction

	// Offers one item and returns at the edge where its transfer takes place.
	task automatic offer_item(logic [2:0] op, word_t a, word_t b, bit fixed, word_t want);
		field_item_t due;

		operation      <= op;
		first_operand  <= a;
		second_operand <= b;
		in_valid       <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		due.op    = op;
		due.a     = a;
		due.b     = b;
		due.value = fixed ? want : field_result(op, a, b);
		awaited_values.push_back(due);
	endtask

	// Bursts of random length separated by random gaps, unless no_gaps is set.
	task automatic pace_sender(bit no_gaps);
		if (!no_gaps) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12))
					@(posedge clk);
				burst_left = $urandom_range(1, 20);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_values.size() != 0)
			@(posedge clk);
	endtask

	initial begin : sender
		bit no_gaps;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		operation      = OP_ADD;
		first_operand  = '0;
		second_operand = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_vectors[i]) begin
			offer_item(directed_vectors[i].op, directed_vectors[i].a, directed_vectors[i].b,
				directed_vectors[i].fixed, directed_vectors[i].want);
			pace_sender(1'b0);
		end
		wait_for_drain();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 600)
				hold_request <= 1'b1;
			if (i == 1000)
				wait_for_drain();
			if (i == 1300)
				steady_run <= 1'b1;
			if (i == 1500)
				steady_run <= 1'b0;
			// Keep offering while the receiver holds off so that the pipeline fills, and through the steady run.
			no_gaps = (i >= 600 && i < 750) || (i >= 1300 && i < 1500);
			offer_item(pick_operation(), pick_operand(), pick_operand(), 1'b0, '0);
			pace_sender(no_gaps);
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && awaited_values.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : receiver
		int  run_left;
		int  held;
		bit  hold_done;
		bit  stall_level;

		run_left    = 0;
		held        = 0;
		hold_done   = 1'b0;
		stall_level = 1'b0;
		out_stall   = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				out_stall <= 1'b1;
				held++;
				if (held == LONG_HOLD)
					hold_done = 1'b1;
			end else if (steady_run) begin
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					stall_level = ($urandom_range(0, 9) < 3);
					run_left    = $urandom_range(1, 6);
				end
				run_left--;
				out_stall <= stall_level;
			end
		end
	end

	always @(posedge clk) begin : result_check
		field_item_t due;

		if (arst_n && out_valid && !out_stall) begin
			if (awaited_values.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTED)
					$display("unexpected result %h with nothing outstanding", value);
			end else begin
				due = awaited_values.pop_front();
				if (value !== due.value) begin
					mismatches++;
					if (mismatches <= MAX_REPORTED)
						$display("mismatch: op %0d a %h b %h expected %h got %h",
							due.op, due.a, due.b, due.value, value);
				end
			end
		end
	end

endmodule
